// File: design/utw_pkg.sv
// Package for the UTF-8 line wrapper: result record, register indexes,
// byte codes and fixed widths. Used by every module of the block.
package utw_pkg;

  localparam int OffW = 13;
  localparam int GlyphPosW = 12;
  localparam int LineW = 8;
  localparam int PixW = 10;
  localparam int GlyphPxW = 6;
  localparam int CfgIdxW = 2;

  localparam logic [LineW-1:0] MaxLines = 8'd255;

  localparam logic [PixW-1:0]     ResetLineWidth = 10'd240;
  localparam logic [GlyphPxW-1:0] ResetNarrowPx  = 6'd8;
  localparam logic [GlyphPxW-1:0] ResetWidePx    = 6'd16;

  localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NARROW_PX  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDE_PX    = 2'd2;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;

  localparam logic KIND_BREAK   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [LineW-1:0] line_number;
    logic [OffW-1:0]  start_offset;
    logic             last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// File: design/utf8_text_line_wrapper_top.sv
// Greedy UTF-8 line wrapper top level. Depends on utw_pkg, utw_core, utw_outq.
// A byte's results enter a four-entry queue as the byte is accepted and leave from its head.
// Throughput: one byte per cycle while the queue has room; a byte that ends a line
// and the buffer gives two results, drained one per cycle while out_ready is high.
// Reset (rst_n low, synchronous): registers to 240/8/16, state and queue empty.
module utf8_text_line_wrapper_top import utw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PixW-1:0]     cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_final_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [LineW-1:0]    out_line_number,
  output logic [OffW-1:0]     out_start_offset,
  output logic                out_last_result
);

  push_t   push;
  result_t res;
  logic    room;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;

  utw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (in_valid && in_ready),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .push       (push)
  );

  utw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_line_number  = res.line_number;
  assign out_start_offset = res.start_offset;
  assign out_last_result  = res.last_result;

endmodule

// File: design/utw_core.sv
// Wrap engine: configuration registers, running line state, and the
// results caused by one accepted byte. Depends on utw_pkg.
module utw_core import utw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PixW-1:0]     cfg_data,
  input  logic                take,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  output push_t               push
);

  logic [PixW-1:0]      line_width_r;
  logic [GlyphPxW-1:0]  narrow_px_r, wide_px_r;
  logic [OffW-1:0]      off_r, off_nxt;
  logic [PixW-1:0]      cw_r, cw_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic [GlyphPosW-1:0] gs_r, gs_nxt;
  logic [LineW-1:0]     lines_r, lines_nxt;

  logic                glyph_en, lf_hit, brk;
  logic [GlyphPxW-1:0] glyph_w;
  logic [OffW-1:0]     glyph_at, brk_off;
  logic [PixW:0]       cw_sum;
  result_t             brk_res, sum_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= ResetLineWidth;
      narrow_px_r  <= ResetNarrowPx;
      wide_px_r    <= ResetWidePx;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width_r <= cfg_data;
        CFG_NARROW_PX:  narrow_px_r  <= cfg_data[GlyphPxW-1:0];
        CFG_WIDE_PX:    wide_px_r    <= cfg_data[GlyphPxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    off_nxt   = off_r;
    cw_nxt    = cw_r;
    pend_nxt  = pend_r;
    gs_nxt    = gs_r;
    lines_nxt = lines_r;
    glyph_en  = 1'b0;
    glyph_w   = narrow_px_r;
    glyph_at  = off_r;
    lf_hit    = 1'b0;
    brk       = 1'b0;
    brk_off   = off_r;
    cw_sum    = '0;

    if (take && !off_r[OffW-1] && lines_r != MaxLines) begin
      off_nxt = off_r + 1'b1;
      if (pend_r != 2'd0) begin
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          glyph_en = 1'b1;
          glyph_w  = wide_px_r;
          glyph_at = {1'b0, gs_r};
        end else if (final_byte) begin
          pend_nxt = 2'd0;
        end
      end else if (!text_byte[7]) begin
        if (text_byte == BYTE_LF) begin
          lf_hit = 1'b1;
        end else if (text_byte != BYTE_CR) begin
          glyph_en = 1'b1;
        end
      end else if ((text_byte & MASK_LEAD2) == CODE_LEAD2) begin
        if (!final_byte) begin
          pend_nxt = 2'd1;
          gs_nxt   = off_r[GlyphPosW-1:0];
        end
      end else if ((text_byte & MASK_LEAD3) == CODE_LEAD3) begin
        if (!final_byte) begin
          pend_nxt = 2'd2;
          gs_nxt   = off_r[GlyphPosW-1:0];
        end
      end
    end else if (take && !off_r[OffW-1]) begin
      off_nxt = off_r + 1'b1;
    end

    if (lf_hit) begin
      brk     = 1'b1;
      brk_off = off_r + 1'b1;
      cw_nxt  = '0;
    end else if (glyph_en) begin
      cw_sum = {1'b0, cw_r} + {{(PixW-GlyphPxW+1){1'b0}}, glyph_w};
      if (cw_r != '0 && cw_sum > {1'b0, line_width_r}) begin
        brk     = 1'b1;
        brk_off = glyph_at;
        cw_nxt  = {{(PixW-GlyphPxW){1'b0}}, glyph_w};
      end else begin
        cw_nxt = cw_sum[PixW-1:0];
      end
    end
    if (brk) lines_nxt = lines_r + 1'b1;

    brk_res.kind         = KIND_BREAK;
    brk_res.line_number  = lines_nxt;
    brk_res.start_offset = brk_off;
    brk_res.last_result  = 1'b0;
    sum_res.kind         = KIND_SUMMARY;
    sum_res.line_number  = lines_nxt;
    sum_res.start_offset = off_nxt;
    sum_res.last_result  = 1'b1;

    push.cnt  = {1'b0, brk} + {1'b0, take && final_byte};
    push.res0 = brk ? brk_res : sum_res;
    push.res1 = sum_res;

    if (take && final_byte) begin
      off_nxt   = '0;
      cw_nxt    = '0;
      pend_nxt  = '0;
      gs_nxt    = '0;
      lines_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      cw_r    <= '0;
      pend_r  <= '0;
      gs_r    <= '0;
      lines_r <= '0;
    end else begin
      off_r   <= off_nxt;
      cw_r    <= cw_nxt;
      pend_r  <= pend_nxt;
      gs_r    <= gs_nxt;
      lines_r <= lines_nxt;
    end
  end

endmodule

// File: design/utw_outq.sv
// Four-entry result queue; takes up to two requests a cycle, hands out one.
// Depends on utw_pkg.
module utw_outq import utw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t    q_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = cnt_r != 3'd0;
  assign out_res   = q_r[rd_r];
  assign room      = cnt_r <= 3'd2;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_nxt  = wr_r + push.cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_r] <= push.res0;
    if (push.cnt == 2'd2) q_r[wr_r + 2'd1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/utw_checker.sv
// Port-level checks for the line wrapper, bound to the top level.
// Depends on utw_pkg.
module utw_checker import utw_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_kind,
  input logic [LineW-1:0] out_line_number,
  input logic [OffW-1:0]  out_start_offset,
  input logic             out_last_result
);

  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == (out_kind == KIND_SUMMARY)))
    else $error("last flag does not match summary kind");

  a_break_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BREAK |-> out_line_number != '0)
    else $error("break reports line zero");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_start_offset <= 13'd4096)
    else $error("offset beyond buffer");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_offset)
      && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind utf8_text_line_wrapper_top utw_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_line_number  (out_line_number),
  .out_start_offset (out_start_offset),
  .out_last_result  (out_last_result)
);

// File: tb/utw_checker.sv
`timescale 1ns / 100ps
// Line-wrap checker: follows register writes and accepted bytes, predicts line starts
// and buffer summaries, and compares them with every accepted result request.
// Depends on utw_pkg for widths, register indexes and byte codes.
module utw_tb_checker import utw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PixW-1:0]    cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_final_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [LineW-1:0]   out_line_number,
  input  logic [OffW-1:0]    out_start_offset,
  input  logic               out_last_result,
  output int                 mismatches,
  output int                 awaited
);

  localparam int BufferBytes = 4096;

  logic [PixW-1:0]      line_px;
  logic [GlyphPxW-1:0]  narrow_px;
  logic [GlyphPxW-1:0]  wide_px;
  logic [OffW-1:0]      offset;
  logic [PixW-1:0]      used_px;
  logic [1:0]           owed;
  logic [GlyphPosW-1:0] glyph_pos;
  logic [LineW-1:0]     lines;
  result_t              line_starts[$];
  int                   errs;

  task automatic clear_text();
    offset = '0;
    used_px = '0;
    owed = '0;
    glyph_pos = '0;
    lines = '0;
  endtask

  task automatic open_line(input logic [OffW-1:0] at);
    lines = lines + 1'b1;
    line_starts.push_back('{kind: KIND_BREAK, line_number: lines, start_offset: at,
                            last_result: 1'b0});
  endtask

  task automatic place_glyph(input logic [GlyphPxW-1:0] w, input logic [OffW-1:0] at);
    logic [PixW:0] sum;
    sum = used_px + w;
    if (used_px != '0 && sum > line_px) begin
      open_line(at);
      used_px = PixW'(w);
    end else begin
      used_px = sum[PixW-1:0];
    end
  endtask

  task automatic wrap_byte(input logic [7:0] b, input logic fin);
    logic [OffW-1:0] pos;
    pos = offset;
    if (pos < BufferBytes) begin
      offset = pos + 1'b1;
      if (lines < MaxLines) begin
        if (owed != '0) begin
          owed = owed - 1'b1;
          if (owed == '0) place_glyph(wide_px, OffW'(glyph_pos));
          else if (fin) owed = '0;
        end else if (!b[7]) begin
          if (b == BYTE_LF) begin
            open_line(pos + 1'b1);
            used_px = '0;
          end else if (b != BYTE_CR) begin
            place_glyph(narrow_px, pos);
          end
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
          if (!fin) begin
            owed = 2'd1;
            glyph_pos = pos[GlyphPosW-1:0];
          end
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
          if (!fin) begin
            owed = 2'd2;
            glyph_pos = pos[GlyphPosW-1:0];
          end
        end
      end
    end
    if (fin) begin
      line_starts.push_back('{kind: KIND_SUMMARY, line_number: lines, start_offset: offset,
                              last_result: 1'b1});
      clear_text();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      line_px = ResetLineWidth;
      narrow_px = ResetNarrowPx;
      wide_px = ResetWidePx;
      clear_text();
      line_starts.delete();
      errs = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_WIDTH: line_px = cfg_data;
          CFG_NARROW_PX:  narrow_px = cfg_data[GlyphPxW-1:0];
          CFG_WIDE_PX:    wide_px = cfg_data[GlyphPxW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) wrap_byte(in_text_byte, in_final_byte);
      if (out_valid && out_ready) begin
        got = '{kind: out_kind, line_number: out_line_number,
                start_offset: out_start_offset, last_result: out_last_result};
        if (line_starts.size() == 0) begin
          $display("%0t unexpected result: expected none, got kind %0d line %0d offset %0d",
                   $time, got.kind, got.line_number, got.start_offset);
          errs++;
        end else begin
          want = line_starts.pop_front();
          check_field("kind", int'(want.kind), int'(got.kind));
          check_field("line_number", int'(want.line_number), int'(got.line_number));
          check_field("start_offset", int'(want.start_offset), int'(got.start_offset));
          check_field("last_result", int'(want.last_result), int'(got.last_result));
        end
      end
    end
    mismatches <= errs;
    awaited <= line_starts.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 line wrapper: clock, reset, text and register requests,
// result back-pressure and the verdict. Depends on utw_pkg,
// utf8_text_line_wrapper_top and utw_tb_checker.
module tb_top;
  import utw_pkg::*;

  localparam int CycleLimit = 3_000_000;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [PixW-1:0]    cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_text_byte;
  logic               in_final_byte;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [LineW-1:0]   out_line_number;
  logic [OffW-1:0]    out_start_offset;
  logic               out_last_result;
  int                 mismatches;
  int                 awaited;
  int                 cycles;
  bit                 calm;
  logic [7:0]         text[$];

  utf8_text_line_wrapper_top DUT (.*);

  utw_tb_checker wrap_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == CycleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // one glyph: mostly well-formed UTF-8, some stray bytes
  task automatic add_glyph();
    int r;
    logic [7:0] rnd;
    r = $urandom_range(99);
    rnd = 8'($urandom);
    if (r < 45) begin
      text.push_back(8'($urandom_range(8'h7E, 8'h20)));
    end else if (r < 52) begin
      text.push_back(BYTE_LF);
    end else if (r < 55) begin
      text.push_back(BYTE_CR);
    end else if (r < 58) begin
      text.push_back({1'b0, rnd[6:0]});
    end else if (r < 72) begin
      text.push_back(CODE_LEAD2 | (rnd & ~MASK_LEAD2));
      rnd = 8'($urandom);
      text.push_back({2'b10, rnd[5:0]});
    end else if (r < 86) begin
      text.push_back(CODE_LEAD3 | (rnd & ~MASK_LEAD3));
      rnd = 8'($urandom);
      text.push_back({2'b10, rnd[5:0]});
      rnd = 8'($urandom);
      text.push_back({2'b10, rnd[5:0]});
    end else begin
      text.push_back(rnd);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_widths(input logic [PixW-1:0] lw, input logic [PixW-1:0] nw,
                                input logic [PixW-1:0] ww);
    logic [CfgIdxW-1:0] idx[3];
    logic [PixW-1:0]    val[3];
    idx = '{CFG_LINE_WIDTH, CFG_NARROW_PX, CFG_WIDE_PX};
    val = '{lw, nw, ww};
    settle();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int len;
    int sent;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_final_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LINE_WIDTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ASCII, CR, 2/3-byte glyphs, blind continuation, strays, LF, cut-off sequence
    text = '{8'h41, BYTE_CR, 8'hC3, 8'hA9, 8'hE4, 8'hB8, 8'hAD, 8'hC3, 8'h41, 8'h80,
             8'hFF, 8'hF0, BYTE_LF, 8'h00, 8'h7F, 8'hE2, 8'h82};
    send_text();
    text = '{BYTE_LF};
    send_text();
    text = '{8'hC2};
    send_text();
    text = '{8'h41, 8'hE2};
    send_text();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_widths(10'd1023, 10'd63, 10'd63);
        1: program_widths(10'd1, 10'd0, 10'd0);
        2: program_widths(10'd1, 10'd63, 10'd63);
        3: program_widths(10'd1023, 10'd0, 10'd0);
        4, 5: program_widths(10'($urandom_range(300, 16)), 10'($urandom_range(24, 1)),
                             10'($urandom_range(40, 1)));
        default: program_widths(10'($urandom), 10'($urandom), 10'($urandom));
      endcase
      calm = (ph == 3);
      sent = 0;
      while (sent < 150) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(120, 30) : $urandom_range(24, 1);
        while (text.size() < len) add_glyph();
        if ($urandom_range(3) == 0) begin
          while (text.size() > len) void'(text.pop_back());
        end
        sent += text.size();
        send_text();
      end
    end
    calm = 1'b0;

    // line limit: every glyph after the first breaks, then a flood of LFs
    program_widths(10'd1, 10'd8, 10'd16);
    repeat (120) text.push_back(8'($urandom_range(8'h7E, 8'h20)));
    repeat (150) text.push_back(BYTE_LF);
    while (text.size() < 300) add_glyph();
    send_text();

    // buffer overrun
    program_widths(ResetLineWidth, 10'(ResetNarrowPx), 10'(ResetWidePx));
    while (text.size() < 4100) add_glyph();
    send_text();

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
design/utw_pkg.sv
design/utw_core.sv
design/utw_outq.sv
design/utf8_text_line_wrapper_top.sv
design/utw_checker.sv
tb/utw_checker.sv
tb/tb_top.sv
